// ===== src/phkv_pkg.sv =====
// ----------------------------------------------------------------------------
// phkv_pkg
// Types, codes and constants shared by the paged hash table key-value engine.
// ----------------------------------------------------------------------------
package phkv_pkg;

  localparam int unsigned SlotsDef    = 256;
  localparam int unsigned MaxPagesDef = 8;
  localparam int unsigned KeyBytesDef = 8;
  localparam int unsigned ValBytesDef = 8;

  localparam logic [31:0] HashSeed  = 32'd5381;
  localparam int unsigned HashShift = 5;

  localparam logic [2:0] ReqGet     = 3'd0;
  localparam logic [2:0] ReqPut     = 3'd1;
  localparam logic [2:0] ReqDel     = 3'd2;
  localparam logic [2:0] ReqNext    = 3'd3;
  localparam logic [2:0] ReqRestart = 3'd4;

  localparam logic [1:0] StOk   = 2'd0;
  localparam logic [1:0] StMiss = 2'd1;
  localparam logic [1:0] StFull = 2'd2;

  localparam logic CfgTableSize = 1'b0;
  localparam logic CfgKeyBytes  = 1'b1;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [63:0] key;
    logic [63:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] key_out;
    logic [63:0] value_out;
  } rsp_t;

  // stored entry: live, key, value (occupancy is kept per entry as a page epoch tag)
  typedef struct packed {
    logic        live;
    logic [63:0] key;
    logic [63:0] value;
  } entry_t;

  typedef struct packed {
    logic load;      // latch request, start hash
    logic hash_step; // one key byte
    logic mod_step;  // one quotient bit of the modulo
    logic rd;        // read entry at current address
    logic wr;        // write entry at current address
    logic next_page; // advance walk page
    logic cur_step;  // advance iterator cursor
    logic cur_clr;   // iterator restart
    logic page_inc;  // open a new page
    logic resp;      // emit result
  } cmd_t;

  typedef struct packed {
    logic       init;       // store clearing after reset
    logic       hash_last;
    logic       mod_last;
    logic       walk_end;   // walk page reached page count
    logic       occ;        // entry at walk address occupied
    logic       live;
    logic       key_eq;
    logic       full;
    logic       cur_end;    // iterator cannot go on
    logic [2:0] req_type;
  } sts_t;

endpackage

// ===== src/phkv_ram.sv =====
// ----------------------------------------------------------------------------
// phkv_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module phkv_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== src/phkv_datapath.sv =====
// ----------------------------------------------------------------------------
// phkv_datapath
// Hash, iterative modulo, page walk addressing, entry store and iterator.
// ----------------------------------------------------------------------------
module phkv_datapath #(
  parameter int unsigned Slots    = 256,
  parameter int unsigned MaxPages = 8,
  parameter int unsigned KeyBytes = 8,
  parameter int unsigned ValBytes = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  phkv_pkg::req_t      req_i,
  input  logic [8:0]          table_size_i,
  input  logic [3:0]          key_bytes_i,
  input  phkv_pkg::cmd_t      cmd_i,
  input  logic [1:0]          status_i,
  output phkv_pkg::sts_t      sts_o,
  output phkv_pkg::rsp_t      rsp_o
);
  import phkv_pkg::*;

  localparam int unsigned SlotW = (Slots > 1) ? $clog2(Slots) : 1;
  localparam int unsigned PageW = $clog2(MaxPages + 1);
  localparam int unsigned PIdxW = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int unsigned Depth = MaxPages * Slots;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned TsW   = $clog2(Slots + 1);
  localparam int unsigned EpW   = 8;

  // effective sizes
  logic [TsW-1:0] ts;
  logic [3:0]     kb;
  always_comb begin
    if (table_size_i == 9'd0) begin
      ts = TsW'(1);
    end else if (32'(table_size_i) > Slots) begin
      ts = TsW'(Slots);
    end else begin
      ts = TsW'(table_size_i);
    end
    if (key_bytes_i == 4'd0) begin
      kb = 4'd1;
    end else if (32'(key_bytes_i) > KeyBytes) begin
      kb = 4'(KeyBytes);
    end else begin
      kb = key_bytes_i;
    end
  end

  logic [63:0] km, vm;
  assign km = (kb >= 4'd8) ? '1 : ((64'd1 << {kb[2:0], 3'b000}) - 64'd1);
  assign vm = (ValBytes >= 8) ? '1 : ((64'd1 << (8 * (ValBytes % 8))) - 64'd1);

  logic [2:0]   req_q;
  logic [63:0]  key_q, val_q;
  logic [63:0]  hash_q;
  logic [3:0]   bcnt_q;
  logic [6:0]   mbit_q;
  logic [63:0]  rem_q;
  logic [SlotW-1:0] slot_q;
  logic [PageW-1:0] wpage_q, page_cnt_q, cpage_q;
  logic [TsW-1:0]   cslot_q;
  logic [AddrW:0]   clr_q;
  logic             init;

  // per page epoch: occupancy marks are stored with the epoch at write time
  logic [EpW-1:0] epoch_q [MaxPages];
  logic [EpW-1:0] ep_ctr_q;

  // clearing pass after reset writes epoch zero to every entry
  assign init = !clr_q[AddrW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_cnt_q <= '0;
      cpage_q    <= '0;
      cslot_q    <= '0;
      clr_q      <= '0;
      ep_ctr_q   <= 8'd1;
      for (int i = 0; i < MaxPages; i++) epoch_q[i] <= '0;
    end else begin
      if (init) clr_q <= clr_q + (AddrW + 1)'(1);
      if (cmd_i.cur_clr) begin
        cpage_q <= '0;
        cslot_q <= '0;
      end else if (cmd_i.cur_step) begin
        if (cslot_q + TsW'(1) >= ts) begin
          cslot_q <= '0;
          cpage_q <= cpage_q + PageW'(1);
        end else begin
          cslot_q <= cslot_q + TsW'(1);
        end
      end
      if (cmd_i.page_inc) begin
        page_cnt_q <= page_cnt_q + PageW'(1);
        epoch_q[page_cnt_q[PIdxW-1:0]] <= ep_ctr_q;
        ep_ctr_q <= (ep_ctr_q == '1) ? 8'd1 : ep_ctr_q + 8'd1;
      end
    end
  end

  logic [63:0] hsum;
  assign hsum = (hash_q << HashShift) + hash_q + 64'(key_q[8*bcnt_q[2:0] +: 8]);

  // restoring division, one quotient bit per step
  logic [64:0] trial;
  assign trial = {rem_q, hash_q[mbit_q[5:0]]} - 65'(ts);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_i.req_type;
      key_q  <= req_i.key & km;
      val_q  <= req_i.value & vm;
      hash_q <= 64'(HashSeed);
      bcnt_q <= '0;
      wpage_q <= '0;
    end
    if (cmd_i.hash_step) begin
      hash_q <= hsum;
      bcnt_q <= bcnt_q + 4'd1;
      mbit_q <= 7'd63;
      rem_q  <= '0;
    end
    if (cmd_i.mod_step) begin
      if (!trial[64]) rem_q <= trial[63:0];
      else rem_q <= {rem_q[62:0], hash_q[mbit_q[5:0]]};
      mbit_q <= mbit_q - 7'd1;
      if (mbit_q == 7'd0) begin
        slot_q <= !trial[64] ? SlotW'(trial[63:0]) : SlotW'({rem_q[62:0], hash_q[0]});
      end
    end
    if (cmd_i.next_page) wpage_q <= wpage_q + PageW'(1);
  end

  // entry store address: walk or iterator, new page uses page count
  logic [PageW-1:0] apage;
  logic [SlotW-1:0] aslot;
  logic             iter;
  assign iter  = (req_q == ReqNext);
  assign apage = iter ? cpage_q : (cmd_i.page_inc ? page_cnt_q : wpage_q);
  assign aslot = iter ? SlotW'(cslot_q) : slot_q;

  logic [AddrW-1:0] addr;
  assign addr = AddrW'(apage[PIdxW-1:0] * Slots + 32'(aslot));

  entry_t         wr_ent, rd_ent;
  logic [EpW-1:0] wr_ep, rd_ep;
  logic           occ;
  logic           keep_key;
  assign occ = (rd_ep == epoch_q[apage[PIdxW-1:0]]) && (epoch_q[apage[PIdxW-1:0]] != '0);
  assign keep_key = occ && !cmd_i.page_inc && (rd_ent.live || req_q != ReqPut);

  always_comb begin
    wr_ent.live  = (req_q == ReqPut);
    wr_ent.key   = keep_key ? rd_ent.key : key_q;
    wr_ent.value = (req_q == ReqPut) ? val_q : rd_ent.value;
    wr_ep        = cmd_i.page_inc ? ep_ctr_q : epoch_q[apage[PIdxW-1:0]];
  end

  phkv_ram #(.Width(EpW + $bits(entry_t)), .Depth(Depth)) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr || init),
    .addr_i  (init ? clr_q[AddrW-1:0] : addr),
    .wdata_i (init ? '0 : {wr_ep, wr_ent}),
    .rdata_o ({rd_ep, rd_ent})
  );

  assign sts_o.init      = init;
  assign sts_o.hash_last = (bcnt_q + 4'd1 >= kb);
  assign sts_o.mod_last  = (mbit_q == 7'd0);
  assign sts_o.walk_end  = (wpage_q >= page_cnt_q);
  assign sts_o.occ       = occ;
  assign sts_o.live      = rd_ent.live;
  assign sts_o.key_eq    = ((rd_ent.key & km) == key_q);
  assign sts_o.full      = (32'(page_cnt_q) >= MaxPages);
  assign sts_o.cur_end   = (cpage_q >= page_cnt_q) || (cslot_q >= ts);
  assign sts_o.req_type  = req_q;

  logic hit;
  assign hit = (status_i == StOk) && (req_q == ReqGet || req_q == ReqNext);
  always_ff @(posedge clk_i) begin
    if (cmd_i.resp) begin
      rsp_o.status    <= status_i;
      rsp_o.key_out   <= (hit && iter) ? rd_ent.key : '0;
      rsp_o.value_out <= hit ? rd_ent.value : '0;
    end
  end
endmodule

// ===== src/phkv_ctrl.sv =====
// ----------------------------------------------------------------------------
// phkv_ctrl
// Request sequencer: hash, modulo, page walk, iterator scan and response.
// ----------------------------------------------------------------------------
module phkv_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  phkv_pkg::sts_t sts_i,
  output phkv_pkg::cmd_t cmd_o,
  output logic [1:0]     status_o,
  output logic           busy_o,
  output logic           done_o
);
  import phkv_pkg::*;

  typedef enum logic [8:0] {
    SIdle  = 9'b000000001,
    SHash  = 9'b000000010,
    SMod   = 9'b000000100,
    SRead  = 9'b000001000,
    SEval  = 9'b000010000,
    SIRead = 9'b000100000,
    SIEval = 9'b001000000,
    SResp  = 9'b010000000,
    SOut   = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      st_q    <= StMiss;
      done_o  <= 1'b0;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
      done_o  <= cmd_o.resp;
    end
  end

  assign busy_o   = (state_q != SIdle) || sts_i.init;
  assign status_o = st_q;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    case (state_q)
      SIdle: begin
        if (start_i && !sts_i.init) begin
          cmd_o.load = 1'b1;
          st_d       = StMiss;
          state_d    = SHash;
        end
      end
      SHash: begin
        case (sts_i.req_type)
          ReqGet, ReqPut, ReqDel: begin
            cmd_o.hash_step = 1'b1;
            if (sts_i.hash_last) state_d = SMod;
          end
          ReqNext: state_d = SIRead;
          ReqRestart: begin
            cmd_o.cur_clr = 1'b1;
            st_d = StOk;
            state_d = SResp;
          end
          default: state_d = SResp;
        endcase
      end
      SMod: begin
        cmd_o.mod_step = 1'b1;
        if (sts_i.mod_last) state_d = SRead;
      end
      SRead: begin
        if (sts_i.walk_end) begin
          if (sts_i.req_type == ReqPut) begin
            if (sts_i.full) begin
              st_d = StFull;
            end else begin
              cmd_o.page_inc = 1'b1;
              cmd_o.wr       = 1'b1;
              st_d           = StOk;
            end
          end
          state_d = SResp;
        end else begin
          state_d = SEval;
        end
      end
      SEval: begin
        state_d = SResp;
        if (!sts_i.occ) begin
          if (sts_i.req_type == ReqPut) begin
            cmd_o.wr = 1'b1;
            st_d = StOk;
          end
        end else if (sts_i.req_type == ReqGet) begin
          if (sts_i.key_eq) begin
            if (sts_i.live) st_d = StOk;
          end else begin
            cmd_o.next_page = 1'b1;
            state_d = SRead;
          end
        end else if (!sts_i.live || sts_i.key_eq) begin
          cmd_o.wr = 1'b1;
          st_d = StOk;
        end else begin
          cmd_o.next_page = 1'b1;
          state_d = SRead;
        end
      end
      SIRead: begin
        if (sts_i.cur_end) begin
          state_d = SOut;
        end else begin
          state_d = SIEval;
        end
      end
      SIEval: begin
        cmd_o.cur_step = 1'b1;
        if (sts_i.occ && sts_i.live) begin
          st_d = StOk;
          state_d = SOut;
        end else begin
          state_d = SIRead;
        end
      end
      SOut: begin
        cmd_o.resp = 1'b1;
        state_d = SIdle;
      end
      SResp: begin
        cmd_o.resp = 1'b1;
        state_d = SIdle;
      end
      default: state_d = SIdle;
    endcase
  end
endmodule

// ===== src/paged_hash_table_kv_engine.sv =====
// ----------------------------------------------------------------------------
// paged_hash_table_kv_engine
// Paged djb2 hash table key-value store with get, put, delete and iterator.
// ----------------------------------------------------------------------------
// sequence: byte-serial hash of the key, bit-serial modulo, then a registered
//   store read and evaluation for each page visited; iterate next reads and
//   checks one slot after another until a live entry or the end; restart
//   only clears the cursor; done_o is registered from the response strobe
// one request at a time; busy high until the done_o beat, no result stall
// reset clears the store with busy high
module paged_hash_table_kv_engine
  import phkv_pkg::*;
#(
  parameter int unsigned Slots    = phkv_pkg::SlotsDef,
  parameter int unsigned MaxPages = phkv_pkg::MaxPagesDef,
  parameter int unsigned KeyBytes = phkv_pkg::KeyBytesDef,
  parameter int unsigned ValBytes = phkv_pkg::ValBytesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  phkv_pkg::req_t req_i,
  output logic           done_o,
  output phkv_pkg::rsp_t rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic           cfg_index_i,
  input  logic [8:0]     cfg_data_i
);
  logic [8:0] table_size_q;
  logic [3:0] key_bytes_q;
  assign cfg_ready_o = !busy && !start;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= 9'd256;
      key_bytes_q  <= 4'd8;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgTableSize: table_size_q <= cfg_data_i;
        CfgKeyBytes:  key_bytes_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  cmd_t       cmd;
  sts_t       sts;
  logic [1:0] status;

  phkv_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .sts_i    (sts),
    .cmd_o    (cmd),
    .status_o (status),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  phkv_datapath #(
    .Slots(Slots), .MaxPages(MaxPages), .KeyBytes(KeyBytes), .ValBytes(ValBytes)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .table_size_i (table_size_q),
    .key_bytes_i  (key_bytes_q),
    .cmd_i        (cmd),
    .status_i     (status),
    .sts_o        (sts),
    .rsp_o        (rsp_o)
  );

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !cmd.load) else $error("load while busy");
  a_done_after_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.resp |=> done_o) else $error("missing done");
  a_wr_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.page_inc |-> cmd.wr) else $error("new page without write");
endmodule
